// ===== src/dgsp_pkg.sv =====
`timescale 1ns / 1ps

package dgsp_pkg;

  // Largest graph the edge store holds
  localparam int MAX_VERTICES = 64;
  // Runs never cover more vertices than the 6-bit result index can name
  localparam int VTX_LIMIT = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
  localparam int IDX_W = (VTX_LIMIT > 1) ? $clog2(VTX_LIMIT) : 1;
  localparam int CNT_W = $clog2(VTX_LIMIT + 1);

  localparam int EDGE_DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int EA_W = $clog2(EDGE_DEPTH);

  localparam int WEIGHT_W = 16;
  localparam int EDGE_W = WEIGHT_W + 1;
  localparam int DIST_W = 23;
  localparam int CAND_W = DIST_W + 1;
  localparam int PRED_W = IDX_W + 1;
  localparam int VCOUNT_W = 7;

  localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
  localparam logic [PRED_W-1:0] PRED_NONE = {1'b1, {IDX_W{1'b0}}};
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_SEL,
    OP_RELAX,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEL,
    ST_MARK,
    ST_RELAX,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic run;
    logic scan;
    op_t  op;
    logic clr_cnt;
    logic clr_best;
    logic mark;
  } dp_cmd_t;

  typedef struct packed {
    logic src_ok;
    logic cnt_end;
    logic rounds_done;
  } dp_status_t;

endpackage

// ===== src/dgsp_ctrl.sv =====
`timescale 1ns / 1ps

module dgsp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 action,
  input  dgsp_pkg::dp_status_t status,
  output dgsp_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  dgsp_pkg::state_t state;
  dgsp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dgsp_pkg::ST_IDLE: begin
        if (start && action && status.src_ok) begin
          state_next = dgsp_pkg::ST_INIT;
        end
      end
      dgsp_pkg::ST_INIT: begin
        if (status.cnt_end) begin
          state_next = status.rounds_done ? dgsp_pkg::ST_OUT : dgsp_pkg::ST_SEL;
        end
      end
      dgsp_pkg::ST_SEL: begin
        if (status.cnt_end) begin
          state_next = dgsp_pkg::ST_MARK;
        end
      end
      dgsp_pkg::ST_MARK: begin
        state_next = dgsp_pkg::ST_RELAX;
      end
      dgsp_pkg::ST_RELAX: begin
        if (status.cnt_end) begin
          state_next = status.rounds_done ? dgsp_pkg::ST_OUT : dgsp_pkg::ST_SEL;
        end
      end
      dgsp_pkg::ST_OUT: begin
        if (status.cnt_end) begin
          state_next = dgsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dgsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.op = dgsp_pkg::OP_INIT;
    busy = 1'b1;
    case (state)
      dgsp_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start && !action;
        cmd.run = start && action && status.src_ok;
        cmd.clr_cnt = cmd.run;
      end
      dgsp_pkg::ST_INIT: begin
        cmd.op = dgsp_pkg::OP_INIT;
        cmd.scan = !status.cnt_end;
        cmd.clr_cnt = status.cnt_end;
        cmd.clr_best = status.cnt_end;
      end
      dgsp_pkg::ST_SEL: begin
        cmd.op = dgsp_pkg::OP_SEL;
        cmd.scan = !status.cnt_end;
        cmd.clr_cnt = status.cnt_end;
      end
      dgsp_pkg::ST_MARK: begin
        cmd.op = dgsp_pkg::OP_SEL;
        cmd.mark = 1'b1;
      end
      dgsp_pkg::ST_RELAX: begin
        cmd.op = dgsp_pkg::OP_RELAX;
        cmd.scan = !status.cnt_end;
        cmd.clr_cnt = status.cnt_end;
        cmd.clr_best = status.cnt_end;
      end
      dgsp_pkg::ST_OUT: begin
        cmd.op = dgsp_pkg::OP_OUT;
        cmd.scan = !status.cnt_end;
        cmd.clr_cnt = status.cnt_end;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/dgsp_dp.sv =====
`timescale 1ns / 1ps

module dgsp_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  dgsp_pkg::dp_cmd_t    cmd,
  output dgsp_pkg::dp_status_t status,
  input  logic                 vertex_count_we,
  input  logic [6:0]           vertex_count,
  input  logic [5:0]           row,
  input  logic [5:0]           col,
  input  logic [15:0]          weight,
  input  logic                 no_edge,
  input  logic [5:0]           source,
  output logic                 result_valid,
  output logic [5:0]           vertex,
  output logic [21:0]          distance,
  output logic                 reachable,
  output logic [5:0]           predecessor,
  output logic                 has_pred,
  output logic                 last
);

  logic [dgsp_pkg::VCOUNT_W-1:0] vcount;
  logic [dgsp_pkg::CNT_W-1:0]    n_eff;

  logic [dgsp_pkg::EDGE_W-1:0] edge_mem [dgsp_pkg::EDGE_DEPTH];
  logic [dgsp_pkg::EDGE_W-1:0] edge_q;
  logic [dgsp_pkg::EA_W-1:0]   edge_waddr;
  logic [dgsp_pkg::EA_W-1:0]   edge_raddr;
  logic                        load_ok;

  logic [dgsp_pkg::DIST_W-1:0] dist_mem [dgsp_pkg::VTX_LIMIT];
  logic [dgsp_pkg::DIST_W-1:0] dist_q;
  logic [dgsp_pkg::PRED_W-1:0] pred_mem [dgsp_pkg::VTX_LIMIT];
  logic [dgsp_pkg::PRED_W-1:0] pred_q;
  logic                        dist_we;
  logic [dgsp_pkg::DIST_W-1:0] dist_wdata;
  logic [dgsp_pkg::PRED_W-1:0] pred_wdata;

  logic [dgsp_pkg::VTX_LIMIT-1:0] visited;
  logic [dgsp_pkg::CNT_W-1:0]     cnt;
  logic [dgsp_pkg::IDX_W-1:0]     cnt_idx;
  logic [dgsp_pkg::CNT_W-1:0]     round;
  logic [dgsp_pkg::IDX_W-1:0]     src;
  logic [dgsp_pkg::IDX_W-1:0]     src_next;
  logic [dgsp_pkg::IDX_W-1:0]     u;
  logic [dgsp_pkg::IDX_W-1:0]     base;
  logic [dgsp_pkg::DIST_W-1:0]    best;
  logic [dgsp_pkg::CAND_W-1:0]    cand;

  logic                       rd_valid;
  logic [dgsp_pkg::IDX_W-1:0] rd_idx;
  dgsp_pkg::op_t              rd_op;

  logic rd_reach;
  logic rd_hp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= dgsp_pkg::VCOUNT_RESET;
    end else if (vertex_count_we) begin
      vcount <= vertex_count;
    end
  end

  // Saturate the count into one .. limit
  always_comb begin
    if (vcount == '0) begin
      n_eff = dgsp_pkg::CNT_W'(1);
    end else if (32'(vcount) > 32'(dgsp_pkg::VTX_LIMIT)) begin
      n_eff = dgsp_pkg::CNT_W'(dgsp_pkg::VTX_LIMIT);
    end else begin
      n_eff = dgsp_pkg::CNT_W'(vcount);
    end
  end

  assign status.src_ok = 32'(source) < 32'(n_eff);
  assign status.cnt_end = cnt == n_eff;
  assign status.rounds_done = round == n_eff;

  assign src_next = dgsp_pkg::IDX_W'(source);
  assign cnt_idx = cnt[dgsp_pkg::IDX_W-1:0];
  assign base = (cmd.op == dgsp_pkg::OP_INIT) ? src : u;

  assign load_ok = (32'(row) < 32'(dgsp_pkg::MAX_VERTICES)) &&
                   (32'(col) < 32'(dgsp_pkg::MAX_VERTICES));
  assign edge_waddr = dgsp_pkg::EA_W'(row) * dgsp_pkg::EA_W'(dgsp_pkg::MAX_VERTICES)
                      + dgsp_pkg::EA_W'(col);
  assign edge_raddr = dgsp_pkg::EA_W'(base) * dgsp_pkg::EA_W'(dgsp_pkg::MAX_VERTICES)
                      + dgsp_pkg::EA_W'(cnt_idx);

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      edge_mem[edge_waddr] <= {no_edge, weight};
    end
    edge_q <= edge_mem[edge_raddr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[rd_idx] <= dist_wdata;
      pred_mem[rd_idx] <= pred_wdata;
    end
    dist_q <= dist_mem[cnt_idx];
    pred_q <= pred_mem[cnt_idx];
  end

  // Scan counter and the one-deep read pipeline behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clr_cnt) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        cnt <= cnt + dgsp_pkg::CNT_W'(1);
      end
      rd_valid <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt_idx;
    rd_op <= cmd.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      round <= dgsp_pkg::CNT_W'(1);
    end else if (cmd.run) begin
      visited <= dgsp_pkg::VTX_LIMIT'(1) << src_next;
      round <= dgsp_pkg::CNT_W'(1);
    end else if (cmd.mark) begin
      visited[u] <= 1'b1;
      round <= round + dgsp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      src <= src_next;
    end
  end

  // Running minimum; ties go to the later index
  always_ff @(posedge clk) begin
    if (cmd.clr_best) begin
      best <= dgsp_pkg::DIST_INF;
      u <= '0;
    end else if (rd_valid && rd_op == dgsp_pkg::OP_SEL && !visited[rd_idx] &&
                 dist_q <= best) begin
      best <= dist_q;
      u <= rd_idx;
    end
  end

  assign cand = dgsp_pkg::CAND_W'(best) +
                dgsp_pkg::CAND_W'(edge_q[dgsp_pkg::WEIGHT_W-1:0]);

  always_comb begin
    dist_we = 1'b0;
    dist_wdata = dgsp_pkg::DIST_INF;
    pred_wdata = dgsp_pkg::PRED_NONE;
    if (rd_valid) begin
      case (rd_op)
        dgsp_pkg::OP_INIT: begin
          dist_we = 1'b1;
          if (rd_idx == src) begin
            dist_wdata = '0;
          end else if (!edge_q[dgsp_pkg::WEIGHT_W]) begin
            dist_wdata = dgsp_pkg::DIST_W'(edge_q[dgsp_pkg::WEIGHT_W-1:0]);
            pred_wdata = {1'b0, src};
          end
        end
        dgsp_pkg::OP_RELAX: begin
          if (!visited[rd_idx] && !edge_q[dgsp_pkg::WEIGHT_W] &&
              cand < dgsp_pkg::CAND_W'(dist_q)) begin
            dist_we = 1'b1;
            dist_wdata = cand[dgsp_pkg::DIST_W-1:0];
            pred_wdata = {1'b0, u};
          end
        end
        default: begin
          dist_we = 1'b0;
        end
      endcase
    end
  end

  assign rd_reach = dist_q != dgsp_pkg::DIST_INF;
  assign rd_hp = !pred_q[dgsp_pkg::IDX_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd_valid && rd_op == dgsp_pkg::OP_OUT;
    end
  end

  always_ff @(posedge clk) begin
    vertex <= 6'(rd_idx);
    distance <= rd_reach ? dist_q[21:0] : 22'd0;
    reachable <= rd_reach;
    predecessor <= rd_hp ? 6'(pred_q[dgsp_pkg::IDX_W-1:0]) : 6'd0;
    has_pred <= rd_hp;
    last <= dgsp_pkg::CNT_W'(rd_idx) == (n_eff - dgsp_pkg::CNT_W'(1));
  end

`ifndef SYNTHESIS
  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("result stream broke before the last vertex");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result followed the last vertex");

  a_pick_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> !visited[u])
    else $error("selected vertex was already visited");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> round < n_eff)
    else $error("selection round beyond vertex count");
`endif

endmodule

// ===== src/dense_graph_shortest_paths.sv =====
`timescale 1ns / 1ps
// Load request: edge entry written at acceptance, busy stays low.
// Run request over n vertices: the first result appears before busy falls, then
// one result per cycle.
// Cost is set by the single read port on the distance and edge memories scanned per round.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous reset returns to idle with vertex_count 64; edge entries are not cleared.

module dense_graph_shortest_paths (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] weight,
  input  logic        no_edge,
  input  logic [5:0]  source,
  input  logic        vertex_count_we,
  input  logic [6:0]  vertex_count,
  output logic        result_valid,
  output logic [5:0]  vertex,
  output logic [21:0] distance,
  output logic        reachable,
  output logic [5:0]  predecessor,
  output logic        has_pred,
  output logic        last
);

  dgsp_pkg::dp_cmd_t    cmd;
  dgsp_pkg::dp_status_t status;

  dgsp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dgsp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .vertex_count_we (vertex_count_we),
    .vertex_count    (vertex_count),
    .row             (row),
    .col             (col),
    .weight          (weight),
    .no_edge         (no_edge),
    .source          (source),
    .result_valid    (result_valid),
    .vertex          (vertex),
    .distance        (distance),
    .reachable       (reachable),
    .predecessor     (predecessor),
    .has_pred        (has_pred),
    .last            (last)
  );

endmodule
